### sv/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request-line parser package
// Phase and status codes, method prefix table and match result type.
// ----------------------------------------------------------------------------
package hrlp_pkg;

   typedef enum logic [1:0] {
      PH_METHOD  = 2'd0,
      PH_URI     = 2'd1,
      PH_SWALLOW = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_METHOD = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_NO_SPACE   = 3'd3,
      ST_TOO_LONG   = 3'd4
   } status_type;

   localparam logic [1:0] METHOD_NONE = 2'd3;
   localparam logic       KIND_URI    = 1'b0;
   localparam logic       KIND_DONE   = 1'b1;

   localparam int NUM_PREFIX = 6;
   localparam int PREFIX_MAX = 5;

   localparam logic [NUM_PREFIX-1:0] MASK_ALL = 6'h3F;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   // GET, get, POST, post, HEAD, head
   localparam logic [7:0] PREFIX_TEXT [NUM_PREFIX][PREFIX_MAX] = '{
      '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00},
      '{8'h67, 8'h65, 8'h74, 8'h20, 8'h00},
      '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20},
      '{8'h70, 8'h6F, 8'h73, 8'h74, 8'h20},
      '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20},
      '{8'h68, 8'h65, 8'h61, 8'h64, 8'h20}
   };

   localparam logic [2:0] PREFIX_LEN [NUM_PREFIX] = '{
      3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5
   };

   typedef struct packed {
      logic                  done;
      logic [1:0]            method;
      logic [NUM_PREFIX-1:0] next_mask;
   } match_type;

endpackage

### sv/hrlp_match.sv
// ----------------------------------------------------------------------------
// HTTP request-line parser: method prefix matcher
// Compares one byte against the live prefixes (of six) at the current position.
// ----------------------------------------------------------------------------
module hrlp_match (
   input  logic [2:0]                      position,
   input  logic [hrlp_pkg::NUM_PREFIX-1:0] live_mask,
   input  logic [7:0]                      data_byte,
   output hrlp_pkg::match_type             result
);
   import hrlp_pkg::*;

   always_comb begin
      result.done      = 1'b0;
      result.method    = METHOD_NONE;
      result.next_mask = '0;
      for (int c = 0; c < NUM_PREFIX; c++) begin
         if (live_mask[c] && (position < PREFIX_LEN[c]) &&
             (PREFIX_TEXT[c][position] == data_byte)) begin
            if (position + 3'd1 == PREFIX_LEN[c]) begin
               result.done   = 1'b1;
               result.method = 2'(c >> 1);
            end else begin
               result.next_mask[c] = 1'b1;
            end
         end
      end
   end

endmodule

### sv/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// HTTP request-line parser
// Streams the URI of a request and reports method, length and status.
// ----------------------------------------------------------------------------
// Request bytes enter on the req_ channel, one per transfer, with req_is_last
// on the final byte of a buffer. The method prefix (GET, POST, HEAD, each all
// upper or all lower case) is consumed silently; each URI byte before the
// first space, NUL, length limit or final byte leaves on the rsp_ channel as
// a URI item, then exactly one done item carries method, length and status.
// After it, bytes are dropped up to the final byte; a fresh request follows.
// Each accepted byte updates the parse state and, if it yields an item, loads
// the output register, so results appear in the cycle after the input transfer.
// One byte is taken every cycle while req_stall is low; the single output
// register sets that figure, freeing itself in the same cycle it is read.
// While rsp_stall holds a waiting item, req_stall is raised and input holds.
// Reset returns the parser to method matching with no item pending.
// ----------------------------------------------------------------------------
module http_request_line_parser #(
   parameter int MAX_URI_LEN = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_uri_byte,
   output logic [1:0] rsp_method_code,
   output logic [7:0] rsp_uri_length,
   output logic [2:0] rsp_parse_status
);
   import hrlp_pkg::*;

   localparam logic [7:0] URI_LIMIT = (MAX_URI_LEN > 255) ? 8'd255 : 8'(MAX_URI_LEN);

   phase_type             phase_ff, phase_in;
   logic [2:0]            pos_ff, pos_in;
   logic [NUM_PREFIX-1:0] mask_ff, mask_in;
   logic [7:0]            count_ff, count_in;
   logic [1:0]            method_ff, method_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       kind_ff;
   logic [7:0] byte_ff;
   logic [1:0] method_out_ff;
   logic [7:0] length_ff;
   status_type status_ff;

   logic       req_accept;
   logic       finish;
   logic       emit_uri;
   status_type status;
   logic [1:0] out_method;
   logic [7:0] out_length;
   match_type  match;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   hrlp_match u_match (
      .position  (pos_ff),
      .live_mask (mask_ff),
      .data_byte (req_data_byte),
      .result    (match)
   );

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      mask_in    = mask_ff;
      count_in   = count_ff;
      method_in  = method_ff;
      finish     = 1'b0;
      emit_uri   = 1'b0;
      status     = ST_OK;
      out_method = method_ff;
      out_length = count_ff;
      if (req_accept) begin
         case (phase_ff)
            PH_METHOD: begin
               if (match.done) begin
                  method_in = match.method;
                  phase_in  = PH_URI;
                  count_in  = '0;
                  if (req_is_last) begin
                     finish = 1'b1;
                     status = ST_NO_SPACE;
                  end
               end else begin
                  mask_in = match.next_mask;
                  pos_in  = pos_ff + 3'd1;
                  if ((match.next_mask == '0) || req_is_last) begin
                     method_in = METHOD_NONE;
                     count_in  = '0;
                     finish    = 1'b1;
                     status    = ST_BAD_METHOD;
                  end
               end
            end
            PH_URI: begin
               if (req_data_byte == SPACE_CHAR) begin
                  finish = 1'b1;
                  status = (count_ff == '0) ? ST_EMPTY : ST_OK;
               end else if (req_data_byte == NUL_CHAR) begin
                  finish = 1'b1;
                  status = ST_NO_SPACE;
               end else if (count_ff >= URI_LIMIT) begin
                  finish = 1'b1;
                  status = ST_TOO_LONG;
               end else if (req_is_last) begin
                  finish = 1'b1;
                  status = ST_NO_SPACE;
               end else begin
                  count_in = count_ff + 8'd1;
                  emit_uri = 1'b1;
               end
            end
            default: begin
               if (req_is_last) begin
                  phase_in  = PH_METHOD;
                  pos_in    = '0;
                  mask_in   = MASK_ALL;
                  count_in  = '0;
                  method_in = METHOD_NONE;
               end
            end
         endcase
         out_method = method_in;
         out_length = count_in;
         if (finish) begin
            if (req_is_last) begin
               phase_in  = PH_METHOD;
               pos_in    = '0;
               mask_in   = MASK_ALL;
               count_in  = '0;
               method_in = METHOD_NONE;
            end else begin
               phase_in = PH_SWALLOW;
            end
         end
      end
   end

   always_comb begin
      if (finish || emit_uri) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_METHOD;
         pos_ff       <= '0;
         mask_ff      <= MASK_ALL;
         count_ff     <= '0;
         method_ff    <= METHOD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         mask_ff      <= mask_in;
         count_ff     <= count_in;
         method_ff    <= method_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish || emit_uri) begin
         kind_ff       <= finish ? KIND_DONE : KIND_URI;
         byte_ff       <= finish ? 8'd0 : req_data_byte;
         method_out_ff <= out_method;
         length_ff     <= out_length;
         status_ff     <= status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item_kind    = kind_ff;
   assign rsp_uri_byte     = byte_ff;
   assign rsp_method_code  = method_out_ff;
   assign rsp_uri_length   = length_ff;
   assign rsp_parse_status = status_ff;

   a_uri_item_has_method: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == KIND_URI) |->
         (rsp_method_code != METHOD_NONE && rsp_parse_status == ST_OK &&
          rsp_uri_length != 8'd0))
      else $error("URI item without method or with non-zero status");

   a_no_method_is_bad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == KIND_DONE && rsp_method_code == METHOD_NONE) |->
         (rsp_parse_status == ST_BAD_METHOD && rsp_uri_length == 8'd0))
      else $error("done item without method must report bad method");

   a_length_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_uri_length <= URI_LIMIT))
      else $error("URI length beyond limit");

   a_uri_phase_has_method: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_URI) |-> (method_ff != METHOD_NONE))
      else $error("URI phase without a matched method");

   a_swallow_after_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && finish && !req_is_last) |=> (phase_ff == PH_SWALLOW))
      else $error("done item not followed by swallow phase");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// HTTP request-line parser testbench
// Sends request buffers one byte per transfer and checks every URI and done
// item against a cycle-free model of the parser kept alongside the block.
// Short directed requests come first, then random requests that are mostly
// well formed; bursty input, patterned output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import hrlp_pkg::*;

   localparam int MAX_URI_LEN = 255;
   localparam int URI_LIMIT   = (MAX_URI_LEN > 255) ? 255 : MAX_URI_LEN;
   localparam int RANDOM_BYTES = 1050;
   localparam int CYCLE_LIMIT = 100000;

   typedef logic [7:0] byte_list_type [$];

   typedef struct {
      logic [7:0] data;
      logic       last;
   } req_byte_type;

   typedef struct {
      logic       kind;
      logic [7:0] uri_byte;
      logic [1:0] method;
      logic [7:0] length;
      status_type status;
   } parse_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_item_kind;
   logic [7:0] rsp_uri_byte;
   logic [1:0] rsp_method_code;
   logic [7:0] rsp_uri_length;
   logic [2:0] rsp_parse_status;

   req_byte_type   pending_bytes [$];
   parse_item_type expected_items [$];

   // parser state
   phase_type             ps_phase  = PH_METHOD;
   logic [2:0]            ps_pos    = 3'd0;
   logic [NUM_PREFIX-1:0] ps_mask   = MASK_ALL;
   logic [7:0]            ps_count  = 8'd0;
   logic [1:0]            ps_method = METHOD_NONE;

   int mismatches = 0;
   int bytes_taken = 0;
   int requests_taken = 0;
   int uri_items = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};
   int cycle_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int seg_left = 0;
   int seg_mode = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   http_request_line_parser #(.MAX_URI_LEN(MAX_URI_LEN)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_uri_byte     (rsp_uri_byte),
      .rsp_method_code  (rsp_method_code),
      .rsp_uri_length   (rsp_uri_length),
      .rsp_parse_status (rsp_parse_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_parse();
      ps_phase  = PH_METHOD;
      ps_pos    = 3'd0;
      ps_mask   = MASK_ALL;
      ps_count  = 8'd0;
      ps_method = METHOD_NONE;
   endfunction

   function automatic void finish_request(input status_type st, input logic last);
      parse_item_type item;
      item = '{KIND_DONE, 8'h00, ps_method, ps_count, st};
      expected_items.push_back(item);
      status_seen[int'(st)]++;
      if (last)
         clear_parse();
      else
         ps_phase = PH_SWALLOW;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic last);
      logic [NUM_PREFIX-1:0] live;
      int hit;
      parse_item_type item;
      live = '0;
      hit = -1;
      case (ps_phase)
         PH_METHOD: begin
            for (int c = 0; c < NUM_PREFIX; c++) begin
               if (ps_mask[c] && ps_pos < PREFIX_LEN[c] && PREFIX_TEXT[c][ps_pos] == b) begin
                  if (ps_pos + 3'd1 == PREFIX_LEN[c])
                     hit = c;
                  else
                     live[c] = 1'b1;
               end
            end
            if (hit >= 0) begin
               ps_method = 2'(hit / 2);
               ps_phase  = PH_URI;
               ps_count  = 8'd0;
               if (last)
                  finish_request(ST_NO_SPACE, 1'b1);
            end else begin
               ps_mask = live;
               ps_pos  = ps_pos + 3'd1;
               if (live == '0 || last) begin
                  ps_method = METHOD_NONE;
                  ps_count  = 8'd0;
                  finish_request(ST_BAD_METHOD, last);
               end
            end
         end
         PH_URI: begin
            if (b == SPACE_CHAR)
               finish_request((ps_count == 8'd0) ? ST_EMPTY : ST_OK, last);
            else if (b == NUL_CHAR)
               finish_request(ST_NO_SPACE, last);
            else if (ps_count >= URI_LIMIT)
               finish_request(ST_TOO_LONG, last);
            else if (last)
               finish_request(ST_NO_SPACE, 1'b1);
            else begin
               ps_count = ps_count + 8'd1;
               item = '{KIND_URI, b, ps_method, ps_count, ST_OK};
               expected_items.push_back(item);
               uri_items++;
            end
         end
         default: begin
            if (last)
               clear_parse();
         end
      endcase
   endfunction

   function automatic logic [7:0] uri_char();
      logic [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (b == SPACE_CHAR);
      return b;
   endfunction

   task automatic queue_request(input byte_list_type bytes);
      for (int i = 0; i < bytes.size(); i++)
         pending_bytes.push_back('{bytes[i], (i == bytes.size() - 1)});
   endtask

   task automatic queue_text(input string text, input int trailer);
      byte_list_type bytes;
      for (int i = 0; i < text.len(); i++)
         bytes.push_back(text[i]);
      if (trailer >= 0)
         bytes.push_back(8'(trailer));
      queue_request(bytes);
   endtask

   task automatic queue_random_request(input int long_len);
      byte_list_type bytes;
      int kind;
      int pfx;
      int sel;
      int pos;
      int cut;
      kind = $urandom_range(0, 99);
      pfx  = $urandom_range(0, NUM_PREFIX - 1);
      if (kind < 80 || long_len > 0) begin
         for (int i = 0; i < PREFIX_LEN[pfx]; i++)
            bytes.push_back(PREFIX_TEXT[pfx][i]);
         if (long_len == 0 && kind >= 70) begin
            pos = $urandom_range(0, bytes.size() - 1);
            // mix the case of one letter, or break the prefix outright
            if (kind < 75 && pos < bytes.size() - 1)
               bytes[pos] = bytes[pos] ^ 8'h20;
            else
               bytes[pos] = 8'($urandom_range(0, 255));
         end
         repeat ((long_len > 0) ? long_len : $urandom_range(0, 12))
            bytes.push_back(uri_char());
         sel = $urandom_range(0, 9);
         if (long_len > 0 || sel < 6)
            bytes.push_back(SPACE_CHAR);
         else if (sel == 6)
            bytes.push_back(NUL_CHAR);
         else if (sel == 7)
            bytes.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 3))
            bytes.push_back(($urandom_range(0, 3) == 0) ? SPACE_CHAR : 8'($urandom_range(0, 255)));
         if (long_len == 0 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, bytes.size());
            while (bytes.size() > cut)
               void'(bytes.pop_back());
         end
      end else begin
         repeat ($urandom_range(1, 6))
            bytes.push_back(8'($urandom_range(0, 255)));
      end
      queue_request(bytes);
   endtask

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // sender: bursts of transfers with random gaps
   always @(posedge clock) begin : drive
      req_byte_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0 || pending_bytes.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left > 0)
               gap_left <= gap_left - 1;
         end else begin
            next_req = pending_bytes.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_req.data;
            req_is_last   <= next_req.last;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: stall pattern in segments, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && bytes_taken >= 200) begin
         rsp_stall    <= 1'b1;
         holdoff_done <= 1'b1;
         holdoff_left <= 299;
      end else begin
         if (seg_left == 0) begin
            seg_left <= $urandom_range(4, 60);
            seg_mode <= $urandom_range(0, 3);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (seg_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // predict on each input transfer, check each output transfer
   always @(posedge clock) begin : watch
      parse_item_type want;
      if (reset) begin
         clear_parse();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_items.size() == 0) begin
               note_mismatch($sformatf(
                  "unexpected item kind %0d byte %02h method %0d len %0d st %0d",
                  rsp_item_kind, rsp_uri_byte, rsp_method_code, rsp_uri_length,
                  rsp_parse_status));
            end else begin
               want = expected_items.pop_front();
               if (rsp_item_kind !== want.kind || rsp_uri_byte !== want.uri_byte ||
                   rsp_method_code !== want.method || rsp_uri_length !== want.length ||
                   rsp_parse_status !== want.status)
                  note_mismatch($sformatf(
                     "exp kind %0d byte %02h method %0d len %0d st %0d, got %0d %02h %0d %0d %0d",
                     want.kind, want.uri_byte, want.method, want.length, want.status,
                     rsp_item_kind, rsp_uri_byte, rsp_method_code, rsp_uri_length,
                     rsp_parse_status));
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            if (req_is_last)
               requests_taken++;
            parse_byte(req_data_byte, req_is_last);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int req_no;
      int directed_count;
      queue_text("x", -1);
      queue_text("gE", 'hFF);
      queue_text("HE", -1);
      queue_text("get ", -1);
      queue_text("head  ", -1);
      queue_text("POST a", 0);
      queue_text("GET ~", 'h80);
      queue_text("post / x", -1);
      directed_count = pending_bytes.size();
      req_no = 0;
      while (pending_bytes.size() < directed_count + RANDOM_BYTES) begin
         // one URI exactly at the limit, one past it
         queue_random_request((req_no == 12) ? URI_LIMIT : ((req_no == 30) ? URI_LIMIT + 3 : 0));
         req_no++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_items.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d requests (%0d bytes), %0d URI items", requests_taken, bytes_taken,
         uri_items);
      $display("Done items: ok %0d, bad method %0d, empty %0d, no space %0d, too long %0d",
         status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
